FILE: sv/gaussian_sobel_magnitude_macros.svh
// Assertion macros for the gradient magnitude block.
// Used by the checker module; needs a clk and an active-low rst_n in scope.
`ifndef GAUSSIAN_SOBEL_MAGNITUDE_MACROS_SVH
`define GAUSSIAN_SOBEL_MAGNITUDE_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define GSM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define GSM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gsm_pkg.sv
// Shared types, constants and the combined blur/Sobel kernel function.
// No dependencies; every file but the assertion macro header imports this package.
package gsm_pkg;

  localparam int DIM_W         = 13;
  localparam int PIX_W         = 24;
  localparam int RING_BITS     = 4;
  localparam int ACC_W         = 21;
  localparam int SQ_W          = 42;
  localparam int DREM_W        = 17;
  localparam int KW_W          = 13;
  localparam int NORM          = 273;
  localparam int SAT_LIMIT     = 256 * NORM;
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int CFG_IDX_W     = 2;

  // Division by the norm as a reciprocal multiply: (r * RECIP_K) >> RECIP_SH
  // equals floor(r / 273) for every r below 123817, which covers all roots
  // that are not saturated.
  localparam int                 RECIP_W  = 17;
  localparam int                 RECIP_SH = 25;
  localparam logic [RECIP_W-1:0] RECIP_K  = 17'd122911;

  localparam logic [DIM_W-1:0]     RST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]     RST_HEIGHT = 13'd480;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  // 5x5 Gaussian taps, row major.
  localparam int GAUSS [25] = '{1, 4, 7, 4, 1,
                                4, 16, 26, 16, 4,
                                7, 26, 41, 26, 7,
                                4, 16, 26, 16, 4,
                                1, 4, 7, 4, 1};

  // One result job handed from the front end to the back end.
  typedef struct packed {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic             row_end;
    logic             frame_end;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SQH,
    BK_SQV,
    BK_ROOT,
    BK_SAT,
    BK_DIV,
    BK_OUT
  } back_state_t;

  // Weight of the 7x7 kernel that is the Sobel operator applied to the
  // Gaussian. col_ofs and row_ofs run 0..6 (offset plus three).
  function automatic logic signed [KW_W-1:0] kern_w(input logic [2:0] col_ofs,
                                                    input logic [2:0] row_ofs,
                                                    input logic vert);
    int acc;
    int i;
    int j;
    int s;
    acc = 0;
    for (int du = 0; du < 3; du++) begin
      for (int dv = 0; dv < 3; dv++) begin
        i = int'(col_ofs) - du;
        j = int'(row_ofs) - dv;
        if (i >= 0 && i < 5 && j >= 0 && j < 5) begin
          if (vert) s = (dv - 1) * ((du == 1) ? 2 : 1);
          else      s = (du - 1) * ((dv == 1) ? 2 : 1);
          acc += s * GAUSS[i * 5 + j];
        end
      end
    end
    return KW_W'(acc);
  endfunction

endpackage

FILE: sv/gsm_line_store.sv
// Ring of sixteen pixel rows: one write port, one registered read port.
// Depends on gsm_pkg.
module gsm_line_store import gsm_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int AW        = RING_BITS + $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [PIX_W-1:0] rd_data
);

  logic [PIX_W-1:0] mem [2**AW];
  logic [PIX_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/gsm_job_queue.sv
// Two-entry queue of result jobs between the front and back ends.
// Depends on gsm_pkg.
module gsm_job_queue import gsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t       slot_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_job;
  end

  assign head  = slot_r[rptr_r];
  assign full  = cnt_r[1];
  assign empty = (cnt_r == 2'd0);

endmodule

FILE: sv/gsm_front.sv
// Front end: accepts beats, stores pixels, tracks positions, issues jobs.
// Depends on gsm_pkg.
module gsm_front import gsm_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int AW        = RING_BITS + $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIM_W-1:0] eff_w,
  input  logic [DIM_W-1:0] eff_h,
  input  logic             cfg_clr,
  input  logic             in_valid,
  input  logic             in_action,
  input  logic [7:0]       in_sample_a,
  input  logic [7:0]       in_sample_b,
  input  logic [7:0]       in_sample_c,
  output logic             in_stall,
  output logic             push,
  output job_t             push_job,
  input  logic             q_full,
  input  logic             q_empty,
  input  logic             back_idle,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [PIX_W-1:0] wr_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int GW = CW + 3;

  logic [DIM_W-1:0] in_col_r, in_col_nxt, in_row_r, in_row_nxt;
  logic [DIM_W-1:0] out_col_r, out_col_nxt, out_row_r, out_row_nxt;
  logic [GW-1:0]    gap_r, gap_nxt, gap_inc, thr;
  logic             wait_r, wait_nxt;
  logic             accept, input_done, is_pixel, emit, last, row_end;

  // Classify the beat.
  always_comb begin
    accept     = in_valid && !in_stall;
    input_done = (in_row_r >= eff_h);
    is_pixel   = !in_action && !input_done;
    gap_inc    = gap_r + GW'(1);
    thr        = GW'(eff_w) + GW'({eff_w, 1'b0}) + GW'(3);
    emit       = is_pixel ? (gap_inc > thr) : (input_done && (out_row_r < eff_h));
    row_end    = (out_col_r == eff_w - DIM_W'(1));
    last       = row_end && (out_row_r == eff_h - DIM_W'(1));
  end

  // Position counters and the frame-boundary wait.
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    gap_nxt     = gap_r;
    wait_nxt    = wait_r && !(back_idle && q_empty);
    if (accept) begin
      if (is_pixel) begin
        gap_nxt = gap_inc;
        if (in_col_r + DIM_W'(1) >= eff_w) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + DIM_W'(1);
        end else begin
          in_col_nxt = in_col_r + DIM_W'(1);
        end
      end
      if (emit) begin
        gap_nxt = gap_nxt - GW'(1);
        if (row_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + DIM_W'(1);
        end else begin
          out_col_nxt = out_col_r + DIM_W'(1);
        end
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          gap_nxt     = '0;
          wait_nxt    = 1'b1;
        end
      end
    end
    if (cfg_clr) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      gap_nxt     = '0;
      wait_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      gap_r     <= '0;
      wait_r    <= 1'b0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      gap_r     <= gap_nxt;
      wait_r    <= wait_nxt;
    end
  end

  // Outputs to the line store, the queue and the input channel.
  assign in_stall           = q_full || wait_r;
  assign wr_en              = accept && is_pixel;
  assign wr_addr            = {in_row_r[RING_BITS-1:0], in_col_r[CW-1:0]};
  assign wr_data            = {in_sample_c, in_sample_b, in_sample_a};
  assign push               = accept && emit;
  assign push_job.col       = out_col_r;
  assign push_job.row       = out_row_r;
  assign push_job.row_end   = row_end;
  assign push_job.frame_end = last;

endmodule

FILE: sv/gsm_back.sv
// Back end: window fetch and filtering, square root, scaling, result register.
// Depends on gsm_pkg.
module gsm_back import gsm_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int AW        = RING_BITS + $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DIM_W-1:0] eff_w,
  input  logic [DIM_W-1:0] eff_h,
  input  logic             q_empty,
  input  job_t             q_head,
  output logic             q_pop,
  output logic [AW-1:0]    rd_addr,
  input  logic [PIX_W-1:0] rd_data,
  output logic             idle,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_magnitude_a,
  output logic [7:0]       out_magnitude_b,
  output logic [7:0]       out_magnitude_c,
  output logic             out_row_end,
  output logic             out_frame_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QP_W = DREM_W + RECIP_W;

  back_state_t state_r, state_nxt;
  job_t        job_r;
  logic [2:0]  ca_r, cb_r, ca_d_r, cb_d_r;
  logic        iss_done_r, vld_d_r;
  logic signed [ACC_W-1:0] hacc_r [3];
  logic signed [ACC_W-1:0] vacc_r [3];
  logic signed [ACC_W-1:0] prod_h [3];
  logic signed [ACC_W-1:0] prod_v [3];
  logic [SQ_W-1:0]   sq_r [3];
  logic [SQ_W-1:0]   res_r [3];
  logic [SQ_W-1:0]   bit_r;
  logic [SQ_W-1:0]   trial [3];
  logic              sat_r [3];
  logic [DREM_W-1:0] drem_r [3];
  logic [QP_W-1:0]   quo_p [3];
  logic [7:0]        q_r [3];
  logic signed [KW_W-1:0] kw_h, kw_v;
  logic signed [DIM_W+1:0] colx, rowx;
  logic [DIM_W-1:0]  col_c, row_c;
  logic              out_valid_r, load;
  logic [7:0]        mag_r [3];
  logic              row_end_r, frame_end_r;

  // Clamped window address for the current tap.
  always_comb begin
    colx = $signed({2'b00, job_r.col}) + $signed({12'b0, ca_r}) - 15'sd3;
    rowx = $signed({2'b00, job_r.row}) + $signed({12'b0, cb_r}) - 15'sd3;
    if (colx < 0)                                    col_c = '0;
    else if (colx > $signed({2'b00, eff_w - DIM_W'(1)})) col_c = eff_w - DIM_W'(1);
    else                                             col_c = colx[DIM_W-1:0];
    if (rowx < 0)                                    row_c = '0;
    else if (rowx > $signed({2'b00, eff_h - DIM_W'(1)})) row_c = eff_h - DIM_W'(1);
    else                                             row_c = rowx[DIM_W-1:0];
    rd_addr = {row_c[RING_BITS-1:0], col_c[CW-1:0]};
  end

  // Weighted taps of the returned pixel, per channel.
  always_comb begin
    kw_h = kern_w(ca_d_r, cb_d_r, 1'b0);
    kw_v = kern_w(ca_d_r, cb_d_r, 1'b1);
    for (int l = 0; l < 3; l++) begin
      prod_h[l] = ACC_W'($signed({1'b0, rd_data[l*8 +: 8]}) * kw_h);
      prod_v[l] = ACC_W'($signed({1'b0, rd_data[l*8 +: 8]}) * kw_v);
      trial[l]  = res_r[l] + bit_r;
    end
  end

  // Reciprocal products for the division by the norm.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo_p[l] = {{RECIP_W{1'b0}}, drem_r[l]} * {{DREM_W{1'b0}}, RECIP_K};
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_FETCH;
        end
      end
      BK_FETCH: if (iss_done_r && !vld_d_r) state_nxt = BK_SQH;
      BK_SQH:   state_nxt = BK_SQV;
      BK_SQV:   state_nxt = BK_ROOT;
      BK_ROOT:  if (bit_r[0]) state_nxt = BK_SAT;
      BK_SAT:   state_nxt = BK_DIV;
      BK_DIV:   state_nxt = BK_OUT;
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      vld_d_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_d_r     <= (state_r == BK_FETCH) && !iss_done_r;
      if (load)           out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath: fetch/accumulate, squares, square root, divide by the norm.
  always_ff @(posedge clk) begin
    ca_d_r <= ca_r;
    cb_d_r <= cb_r;
    case (state_r)
      BK_IDLE: begin
        job_r      <= q_head;
        ca_r       <= '0;
        cb_r       <= '0;
        iss_done_r <= 1'b0;
        for (int l = 0; l < 3; l++) begin
          hacc_r[l] <= '0;
          vacc_r[l] <= '0;
        end
      end
      BK_FETCH: begin
        if (!iss_done_r) begin
          if (ca_r == 3'd6) begin
            ca_r <= '0;
            if (cb_r == 3'd6) iss_done_r <= 1'b1;
            else              cb_r <= cb_r + 3'd1;
          end else begin
            ca_r <= ca_r + 3'd1;
          end
        end
        if (vld_d_r) begin
          for (int l = 0; l < 3; l++) begin
            hacc_r[l] <= hacc_r[l] + prod_h[l];
            vacc_r[l] <= vacc_r[l] + prod_v[l];
          end
        end
      end
      BK_SQH: begin
        for (int l = 0; l < 3; l++)
          sq_r[l] <= $unsigned(SQ_W'(hacc_r[l]) * SQ_W'(hacc_r[l]));
      end
      BK_SQV: begin
        for (int l = 0; l < 3; l++) begin
          sq_r[l]  <= sq_r[l] + $unsigned(SQ_W'(vacc_r[l]) * SQ_W'(vacc_r[l]));
          res_r[l] <= '0;
        end
        bit_r <= SQ_W'(1) << (SQ_W - 2);
      end
      BK_ROOT: begin
        for (int l = 0; l < 3; l++) begin
          if (sq_r[l] >= trial[l]) begin
            sq_r[l]  <= sq_r[l] - trial[l];
            res_r[l] <= (res_r[l] >> 1) + bit_r;
          end else begin
            res_r[l] <= res_r[l] >> 1;
          end
        end
        bit_r <= bit_r >> 2;
      end
      BK_SAT: begin
        for (int l = 0; l < 3; l++) begin
          sat_r[l]  <= (res_r[l] >= SQ_W'(SAT_LIMIT));
          drem_r[l] <= res_r[l][DREM_W-1:0];
        end
      end
      BK_DIV: begin
        for (int l = 0; l < 3; l++) q_r[l] <= quo_p[l][RECIP_SH +: 8];
      end
      default: begin
      end
    endcase
    // Result register.
    if (load) begin
      for (int l = 0; l < 3; l++) mag_r[l] <= sat_r[l] ? 8'hFF : q_r[l];
      row_end_r   <= job_r.row_end;
      frame_end_r <= job_r.frame_end;
    end
  end

  assign idle            = (state_r == BK_IDLE);
  assign out_valid       = out_valid_r;
  assign out_magnitude_a = mag_r[0];
  assign out_magnitude_b = mag_r[1];
  assign out_magnitude_c = mag_r[2];
  assign out_row_end     = row_end_r;
  assign out_frame_end   = frame_end_r;

endmodule

FILE: sv/gaussian_sobel_magnitude.sv
// Top level of the Gaussian blur plus Sobel gradient magnitude block.
// Depends on gsm_pkg, gsm_line_store, gsm_job_queue, gsm_front, gsm_back.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   action, sample_a..c
//   out_     output     out_valid/out_stall magnitude_a..c, row_end, frame_end
//   cfg_     input      cfg_valid/cfg_ready index, data (width, height)
//
// A pixel beat is taken while in_stall is low; each result then passes through the
// back end in order: taking the job, the 49 window reads through the single
// registered line-store read port, squaring of both sums, 21 square-root steps,
// a saturation check, a reciprocal multiply and the load of the result register.
// Reset is synchronous; the line store is not cleared and holds no valid bits.
// The front end runs up to two jobs ahead and waits at a frame boundary until
// the back end is empty. A stalled result holds the back end.
module gaussian_sobel_magnitude import gsm_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [7:0]           in_sample_a,
  input  logic [7:0]           in_sample_b,
  input  logic [7:0]           in_sample_c,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_magnitude_a,
  output logic [7:0]           out_magnitude_b,
  output logic [7:0]           out_magnitude_c,
  output logic                 out_row_end,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  localparam int AW = RING_BITS + $clog2(MAX_WIDTH);

  logic [DIM_W-1:0] width_r, height_r, eff_w, eff_h;
  logic             cfg_wr, cfg_clr;
  logic             push, pop, q_full, q_empty, back_idle, wr_en;
  job_t             push_job, head;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [PIX_W-1:0] wr_data, rd_data;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_clr   = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else if (cfg_wr) begin
      if (cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
    end
  end

  // Frame size with zero raised to one and the width limited to the line store.
  always_comb begin
    if (width_r == '0)                          eff_w = DIM_W'(1);
    else if ({1'b0, width_r} > (DIM_W+1)'(MAX_WIDTH)) eff_w = DIM_W'(MAX_WIDTH);
    else                                        eff_w = width_r;
    eff_h = (height_r == '0) ? DIM_W'(1) : height_r;
  end

  gsm_front #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_front (
    .clk, .rst_n, .eff_w, .eff_h, .cfg_clr,
    .in_valid, .in_action, .in_sample_a, .in_sample_b, .in_sample_c, .in_stall,
    .push, .push_job, .q_full, .q_empty, .back_idle,
    .wr_en, .wr_addr, .wr_data
  );

  gsm_job_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop, .head, .full(q_full), .empty(q_empty)
  );

  gsm_line_store #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_store (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  gsm_back #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_back (
    .clk, .rst_n, .eff_w, .eff_h, .q_empty, .q_head(head), .q_pop(pop),
    .rd_addr, .rd_data, .idle(back_idle),
    .out_valid, .out_stall, .out_magnitude_a, .out_magnitude_b, .out_magnitude_c,
    .out_row_end, .out_frame_end
  );

endmodule

FILE: sv/gsm_checker.sv
// Port-level checks for the gradient magnitude block, bound to the top level.
// Depends on gsm_pkg and gaussian_sobel_magnitude_macros.svh.
`include "gaussian_sobel_magnitude_macros.svh"

module gsm_checker import gsm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_magnitude_a,
  input logic       out_row_end,
  input logic       out_frame_end
);

  // A stalled result beat stays offered.
  `GSM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

  // A stalled result beat keeps its magnitude.
  `GSM_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_magnitude_a), "payload changed")

  // The last result of a frame also closes its row.
  `GSM_ASSERT_IMP(a_frame_row, out_valid && out_frame_end, out_row_end, "frame end without row end")

  // A new frame cannot produce a result right after the previous frame ends.
  `GSM_ASSERT_NXT(a_frame_gap, out_valid && out_frame_end && !out_stall, !out_valid, "result right after frame end")

endmodule

bind gaussian_sobel_magnitude gsm_checker u_checker (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for gaussian_sobel_magnitude: raster frames in, gradient magnitudes out.
// Depends on gsm_pkg and the RTL only; a built-in predictor computes every expected result beat.
`timescale 1ns / 100ps

module tb_top;
  import gsm_pkg::*;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int RING = 16;
  localparam int COL_MAX = 4096;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int TAPS [25] = '{1, 4, 7, 4, 1, 4, 16, 26, 16, 4, 7, 26, 41, 26, 7,
                               4, 16, 26, 16, 4, 1, 4, 7, 4, 1};

  typedef struct packed {
    logic       action;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic       row_end;
    logic       frame_end;
  } grad_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = ACT_DRAIN;
  logic [7:0] in_sample_a = '0;
  logic [7:0] in_sample_b = '0;
  logic [7:0] in_sample_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_magnitude_a;
  logic [7:0] out_magnitude_b;
  logic [7:0] out_magnitude_c;
  logic out_row_end;
  logic out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  pixel_beat_t pixels_pending[$];
  grad_beat_t mags_due[$];
  pixel_beat_t next_pixel;
  grad_beat_t seen_mag;
  grad_beat_t want_mag;
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Predictor state: pixel ring, size registers and raster counters.
  logic [23:0] pix_ring [RING][COL_MAX];
  int unsigned reg_w, reg_h, eff_w, eff_h;
  int unsigned in_col, in_row, out_col, out_row;

  gaussian_sobel_magnitude dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void resize_frame();
    eff_w = (reg_w < 1) ? 1 : (reg_w > COL_MAX) ? COL_MAX : reg_w;
    eff_h = (reg_h < 1) ? 1 : reg_h;
  endfunction

  function automatic void clear_raster();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic longint fetch_px(int col, int row, int ch);
    if (col < 0) col = 0;
    if (col > int'(eff_w) - 1) col = int'(eff_w) - 1;
    if (row < 0) row = 0;
    if (row > int'(eff_h) - 1) row = int'(eff_h) - 1;
    return longint'((pix_ring[row % RING][col] >> (8 * ch)) & 24'hFF);
  endfunction

  function automatic longint blur_at(int u, int v, int ch);
    longint acc;
    acc = 0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        acc += TAPS[i * 5 + j] * fetch_px(u + i - 2, v + j - 2, ch);
    return acc;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] grad_mag(int x, int y, int ch);
    longint b [3][3];
    longint h, v;
    longint unsigned q;
    for (int du = 0; du < 3; du++)
      for (int dv = 0; dv < 3; dv++)
        b[du][dv] = blur_at(x + du - 1, y + dv - 1, ch);
    h = (b[2][0] - b[0][0]) + 2 * (b[2][1] - b[0][1]) + (b[2][2] - b[0][2]);
    v = (b[0][2] + 2 * b[1][2] + b[2][2]) - (b[0][0] + 2 * b[1][0] + b[2][0]);
    q = root_floor(longint'(h * h + v * v)) / NORM;
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  // Advance the predictor by one accepted input beat.
  function automatic void predict_beat(pixel_beat_t p);
    int unsigned total, in_idx, out_idx;
    bit filled, emit, last;
    grad_beat_t r;
    total = eff_w * eff_h;
    in_idx = in_row * eff_w + in_col;
    out_idx = out_row * eff_w + out_col;
    filled = in_row >= eff_h;
    if (p.action == ACT_PIXEL && !filled) begin
      pix_ring[in_row % RING][in_col] = {p.c, p.b, p.a};
      in_col++;
      if (in_col >= eff_w) begin
        in_col = 0;
        in_row++;
      end
      in_idx++;
      emit = (in_idx - out_idx) > 3 * eff_w + 3;
    end else begin
      emit = filled && out_idx < total;
    end
    if (!emit) return;
    r.a = grad_mag(out_col, out_row, 0);
    r.b = grad_mag(out_col, out_row, 1);
    r.c = grad_mag(out_col, out_row, 2);
    last = (out_idx + 1 == total);
    r.row_end = (out_col == eff_w - 1);
    r.frame_end = last;
    mags_due = {mags_due, r};
    out_col++;
    if (out_col >= eff_w) begin
      out_col = 0;
      out_row++;
    end
    if (last) clear_raster();
  endfunction

  // Driver: offer queued input beats, idling at random between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_beat('{in_action, in_sample_a, in_sample_b, in_sample_c});
      if (!in_valid || !in_stall) begin
        if (pixels_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
          next_pixel = pixels_pending.pop_front();
          in_action <= next_pixel.action;
          in_sample_a <= next_pixel.a;
          in_sample_b <= next_pixel.b;
          in_sample_c <= next_pixel.c;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with an occasional long hold-off.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_asked;
    end
    out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
  end

  // Monitor: compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_mag = '{out_magnitude_a, out_magnitude_b, out_magnitude_c,
                   out_row_end, out_frame_end};
      if (mags_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h", seen_mag);
      end else begin
        want_mag = mags_due.pop_front();
        if (want_mag !== seen_mag) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected a=%0d b=%0d c=%0d re=%b fe=%b,",
                      " got a=%0d b=%0d c=%0d re=%b fe=%b"},
                     want_mag.a, want_mag.b, want_mag.c, want_mag.row_end,
                     want_mag.frame_end, seen_mag.a, seen_mag.b, seen_mag.c,
                     seen_mag.row_end, seen_mag.frame_end);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Wait until every input beat is in and every result is out, then let the block go quiet.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pixels_pending.size() != 0 || in_valid || mags_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) reg_w = val;
    else if (idx == REG_HEIGHT) reg_h = val;
    if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
      clear_raster();
      resize_frame();
    end
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_beat(logic act, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    pixel_beat_t p;
    p = '{act, a, b, c};
    pixels_pending = {pixels_pending, p};
  endfunction

  // One well-formed frame with some noise: early drains and pixels that act as drains.
  function automatic int push_frame();
    int unsigned n, pending_out;
    n = 0;
    for (int unsigned k = 0; k < eff_w * eff_h; k++) begin
      if ($urandom_range(19) == 0) begin
        push_beat(ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        n++;
      end
      push_beat(ACT_PIXEL, rand_sample(), rand_sample(), rand_sample());
      n++;
    end
    pending_out = (eff_w * eff_h < 3 * eff_w + 3) ? eff_w * eff_h : 3 * eff_w + 3;
    for (int unsigned k = 0; k < pending_out; k++) begin
      push_beat(($urandom_range(4) == 0) ? ACT_PIXEL : ACT_DRAIN,
                8'($urandom), 8'($urandom), 8'($urandom));
      n++;
    end
    for (int k = $urandom_range(2); k > 0; k--) begin
      push_beat(ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
      n++;
    end
    return n;
  endfunction

  initial begin
    int beats;
    int phase;
    reg_w = RST_WIDTH;
    reg_h = RST_HEIGHT;
    resize_frame();
    clear_raster();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Widest and tallest setting: a partial frame that yields nothing, then abandoned.
    write_reg(REG_WIDTH, 13'h1FFF);
    write_reg(REG_HEIGHT, 13'h1FFF);
    push_beat(ACT_DRAIN, 8'hFF, 8'h00, 8'hFF);
    for (int k = 0; k < 10; k++)
      push_beat(ACT_PIXEL, (k % 2) ? 8'hFF : 8'h00, 8'($urandom), (k % 2) ? 8'h00 : 8'hFF);
    push_beat(ACT_DRAIN, 8'h00, 8'hFF, 8'h00);
    wait_quiet();
    write_reg(REG_SPARE_LO, 13'h1555);
    write_reg(REG_SPARE_HI, 13'h0AAA);

    // Zero sizes clamp to a single pixel.
    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'd0);
    push_beat(ACT_PIXEL, 8'hFF, 8'h80, 8'h00);
    push_beat(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    push_beat(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    wait_quiet();

    // Hard edges to drive the magnitude into saturation.
    write_reg(REG_WIDTH, 13'd3);
    write_reg(REG_HEIGHT, 13'd2);
    for (int k = 0; k < 6; k++)
      push_beat(ACT_PIXEL, (k < 3) ? 8'hFF : 8'h00, (k % 2) ? 8'hFF : 8'h00, 8'h7F);
    push_beat(ACT_PIXEL, 8'hAA, 8'h55, 8'hAA);
    for (int k = 0; k < 6; k++) push_beat(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
    wait_quiet();

    // Random frames over several sizes and idling and stall phases.
    for (int seg = 0; seg < 16; seg++) begin
      phase = seg / 4;
      idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 20 : 76) : 0;
      stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 20 : 76) : 0;
      if (seg % 4 == 3) begin
        idle_pct = 0;
        stall_pct = 0;
      end
      case ($urandom_range(3))
        0: write_reg(REG_WIDTH, 13'd1);
        1: write_reg(REG_WIDTH, 13'($urandom_range(24, 1)));
        default: write_reg(REG_WIDTH, 13'($urandom_range(8, 1)));
      endcase
      write_reg(REG_HEIGHT, 13'($urandom_range(6, 1)));
      if (seg == 1) begin
        @(posedge clk);
        hold_asked <= hold_asked + 1;
      end
      beats = 0;
      while (beats < 52) beats += push_frame();
      wait_quiet();
    end

    if (mismatches == 0 && mags_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
